// File: hdl/fixed_point_fft_ifft_assert.svh
`ifndef FIXED_POINT_FFT_IFFT_ASSERT_SVH
`define FIXED_POINT_FFT_IFFT_ASSERT_SVH
// assertion helpers
`ifndef SYNTHESIS
`define FFA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FFA_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT(label, clk, rst_n, prop)
`define FFA_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

// File: hdl/ffi_pkg.sv
package ffi_pkg;
  localparam int unsigned Points = 1024;
  localparam int unsigned Lg = $clog2(Points);
  localparam int unsigned QuarterPts = Points / 4;
  localparam longint unsigned PiStep = 64'hC90FDAA22168C235 / 64'(Points);

  localparam logic [2:0] AddrDir = 3'd0;
  localparam logic [2:0] AddrCenter = 3'd4;

  typedef logic [Lg-1:0] addr_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COPY_RD, ST_COPY_WR, ST_BF_RD_A, ST_BF_RD_B, ST_BF_MUL,
    ST_BF_SUM, ST_BF_WR_A, ST_BF_WR_B, ST_SCALE_RD, ST_SCALE_WR
  } state_e;

  typedef struct packed {
    logic start;
    logic inv;
    logic [15:0] center;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } stat_t;

  // signed quotient truncated toward zero by shift and subtract
  function automatic longint div_trunc(input longint num, input longint den);
    longint n_mag, d_mag, q, r;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((n_mag >> b) & 1);
      if (r >= d_mag) begin
        r = r - d_mag;
        q = q | (longint'(1) << b);
      end
    end
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [15:0] quarter_cos(input int unsigned r);
    longint unsigned x62;
    longint x, x2, term, sum, v;
    x62 = PiStep * 64'(2 * r);
    x = longint'((x62 + 64'h80000000) >> 32);
    x2 = (x * x) >>> 30;
    term = longint'(1) << 30;
    sum = term;
    for (int n = 1; n <= 14; n++) begin
      term = div_trunc(-(term * x2 / 64'sd1073741824), longint'((2 * n - 1) * (2 * n)));
      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] cos_at(input int unsigned k);
    logic signed [15:0] c;
    if (k <= QuarterPts) c = quarter_cos(k);
    else if (k <= 2 * QuarterPts) c = -quarter_cos(2 * QuarterPts - k);
    else if (k <= 3 * QuarterPts) c = -quarter_cos(k - 2 * QuarterPts);
    else c = quarter_cos(Points - k);
    return c;
  endfunction

  typedef logic signed [15:0] cos_tab_t [Points];

  function automatic cos_tab_t make_tab();
    cos_tab_t t;
    for (int k = 0; k < Points; k++) t[k] = cos_at(k);
    return t;
  endfunction

  localparam cos_tab_t CosTab = make_tab();

  function automatic addr_t bitrev(input addr_t a);
    addr_t r;
    for (int b = 0; b < Lg; b++) r[Lg-1-b] = a[b];
    return r;
  endfunction
endpackage

// File: hdl/ffi_stream_if.sv
interface ffi_stream_if #(parameter int unsigned Width = 64);
  logic valid;
  logic ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fixed_point_fft_ifft.sv
// Frame FFT / inverse FFT over 1024 points. Each transfer on the input carries one sample
// and, once a frame has been transformed, returns one bin of the previous frame. After the
// last sample of a frame the input stalls while the shared butterfly unit works: copy and
// bit reversal into the working memory, the 5120 butterflies, scaling into the result bank
// and then publishing the frame. Otherwise the input takes one sample per cycle while the
// first frame loads; while bins are returned it takes no new sample while the bin of the
// last one is pending, and it waits while a bin is held by the receiver. The direction and
// sample offset registers are taken when the last sample of a frame arrives.
module fixed_point_fft_ifft
  import ffi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ffi_stream_if.sink in_if,
  ffi_stream_if.source out_if,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  `include "fixed_point_fft_ifft_assert.svh"

  logic dir_q;
  logic [15:0] center_q;
  addr_t pos_q;
  logic have_q, ovf_q;
  logic pend_q, ovalid_q, olast_q, oovf_q;
  addr_t oidx_q, ridx_q;
  job_t job;
  stat_t stat;
  logic [31:0] rd_re, rd_im;
  logic acc, start;

  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      AddrDir: prdata = {31'd0, dir_q};
      AddrCenter: prdata = {16'd0, center_q};
      default: prdata = '0;
    endcase
  end

  assign in_if.ready = !stat.busy && !stat.done && !job.start && !pend_q
                     && (!ovalid_q || out_if.ready);
  assign acc = in_if.valid && in_if.ready;
  assign start = acc && (pos_q == addr_t'(Points - 1));
  always_comb begin
    job.start = 1'b0;
    job.inv = dir_q;
    job.center = center_q;
  end
  job_t job_l;
  always_comb begin
    job_l = job;
    job_l.start = start;
  end

  ffi_engine u_eng (
    .clk_i, .rst_ni, .job_i(job_l), .stat_o(stat),
    .ld_we_i(acc), .ld_addr_i(pos_q),
    .ld_re_i(in_if.data[63:32]), .ld_im_i(in_if.data[31:0]),
    .rd_addr_i(pos_q), .rd_re_o(rd_re), .rd_im_o(rd_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      center_q <= 16'd2048;
      pos_q <= '0;
      have_q <= 1'b0;
      ovf_q <= 1'b0;
      pend_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr == AddrDir) dir_q <= pwdata[0];
        if (paddr == AddrCenter) center_q <= pwdata[15:0];
      end
      if (out_if.ready) ovalid_q <= 1'b0;
      pend_q <= 1'b0;
      if (acc) begin
        pos_q <= pos_q + 1'b1;
        if (have_q) pend_q <= 1'b1;
      end
      if (pend_q) ovalid_q <= 1'b1;
      if (stat.done) begin
        have_q <= 1'b1;
        ovf_q <= stat.ovf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) ridx_q <= pos_q;
    if (pend_q) begin
      oidx_q <= ridx_q;
      olast_q <= (ridx_q == addr_t'(Points - 1));
      oovf_q <= ovf_q;
    end
  end

  logic [31:0] ore_q, oim_q;
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      ore_q <= rd_re;
      oim_q <= rd_im;
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data = {ore_q, oim_q, oidx_q, olast_q, oovf_q};

  `FFA_ASSERT(a_no_overrun, clk_i, rst_ni, pend_q |-> (!ovalid_q || out_if.ready))
  `FFA_ASSERT_NEXT(a_busy_stall, clk_i, rst_ni, stat.busy, 1'b1)
  `FFA_ASSERT(a_busy_no_accept, clk_i, rst_ni, stat.busy |-> !acc)
endmodule

// File: hdl/ffi_engine.sv
module ffi_engine
  import ffi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  output stat_t stat_o,
  // load bank write
  input  logic ld_we_i,
  input  addr_t ld_addr_i,
  input  logic [31:0] ld_re_i,
  input  logic [31:0] ld_im_i,
  // result bank read
  input  addr_t rd_addr_i,
  output logic [31:0] rd_re_o,
  output logic [31:0] rd_im_o
);
  `include "fixed_point_fft_ifft_assert.svh"

  logic [31:0] ld_re_mem [Points];
  logic [31:0] ld_im_mem [Points];
  logic [31:0] wk_re_mem [Points];
  logic [31:0] wk_im_mem [Points];
  logic [31:0] out_re_mem [Points];
  logic [31:0] out_im_mem [Points];

  state_e state_q, state_d;
  logic inv_q;
  logic [15:0] center_q;
  logic [Lg:0] cnt_q, cnt_d;
  logic [$clog2(Lg+1)-1:0] stg_q, stg_d;
  logic ovf_q, ovf_d;
  logic done_q;

  logic [31:0] lr_q, li_q, wr_q, wi_q;
  logic signed [31:0] ur_q, ui_q;
  logic signed [47:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [31:0] tr_q, ti_q, dr_q, di_q;
  logic signed [15:0] cw_q, sw_q;

  addr_t a_idx, b_idx, tw_idx, cnt_lo;
  addr_t half_m;
  logic [Lg-1:0] jmask;

  assign cnt_lo = cnt_q[Lg-1:0];
  assign half_m = addr_t'((1 << stg_q) - 1);
  assign jmask = half_m;
  always_comb begin
    a_idx = ((cnt_lo & ~jmask) << 1) | (cnt_lo & jmask);
    b_idx = a_idx | addr_t'(1 << stg_q);
    tw_idx = addr_t'((cnt_lo & jmask) << (Lg - 1 - stg_q));
  end

  always_ff @(posedge clk_i) begin
    if (ld_we_i) begin
      ld_re_mem[ld_addr_i] <= ld_re_i;
      ld_im_mem[ld_addr_i] <= ld_im_i;
    end
    rd_re_o <= out_re_mem[rd_addr_i];
    rd_im_o <= out_im_mem[rd_addr_i];
  end

  logic signed [31:0] src_re, src_im;
  logic signed [31:0] wrt_re, wrt_im;
  addr_t wrt_addr, rda;
  logic wrt_en;

  always_comb begin
    rda = a_idx;
    case (state_q)
      ST_BF_RD_B: rda = b_idx;
      ST_SCALE_RD: rda = cnt_lo;
      default: rda = a_idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    lr_q <= ld_re_mem[cnt_lo];
    li_q <= ld_im_mem[cnt_lo];
    wr_q <= wk_re_mem[rda];
    wi_q <= wk_im_mem[rda];
    cw_q <= CosTab[tw_idx];
    sw_q <= CosTab[addr_t'(tw_idx + addr_t'(3 * QuarterPts))];
  end

  // twiddle with sign by direction
  logic signed [15:0] wi_tw;
  assign wi_tw = inv_q ? sw_q : -sw_q;

  function automatic logic signed [31:0] rnd(input logic signed [47:0] p);
    logic signed [47:0] t;
    t = (p + 48'sd16384) >>> 15;
    return t[31:0];
  endfunction

  logic signed [31:0] t_r, t_i, s_r, s_i, d_r, d_i;
  logic ov_mul, ov_bf;
  always_comb begin
    t_r = rnd(p0_q) - rnd(p1_q);
    t_i = rnd(p2_q) + rnd(p3_q);
    ov_mul = ((rnd(p0_q) ^ rnd(p1_q)) & (rnd(p0_q) ^ t_r)) >> 31 != 0
           || ((rnd(p2_q) ^ t_i) & (rnd(p3_q) ^ t_i)) >> 31 != 0;
    s_r = ur_q + tr_q;
    s_i = ui_q + ti_q;
    d_r = ur_q - tr_q;
    d_i = ui_q - ti_q;
    ov_bf = (((ur_q ^ s_r) & (tr_q ^ s_r)) >> 31 != 0)
         || (((ui_q ^ s_i) & (ti_q ^ s_i)) >> 31 != 0)
         || (((ur_q ^ tr_q) & (ur_q ^ d_r)) >> 31 != 0)
         || (((ui_q ^ ti_q) & (ui_q ^ d_i)) >> 31 != 0);
  end

  always_comb begin
    wrt_en = 1'b0;
    wrt_addr = a_idx;
    wrt_re = s_r;
    wrt_im = s_i;
    src_re = '0;
    src_im = '0;
    case (state_q)
      ST_COPY_WR: begin
        wrt_en = 1'b1;
        wrt_addr = bitrev(addr_t'(cnt_lo));
        if (inv_q) begin
          src_re = lr_q;
          src_im = li_q;
        end else begin
          src_re = $signed({16'd0, lr_q[15:0]}) - $signed({16'd0, center_q});
          src_im = '0;
        end
        wrt_re = src_re;
        wrt_im = src_im;
      end
      ST_BF_WR_A: begin
        wrt_en = 1'b1;
        wrt_addr = a_idx;
        wrt_re = s_r;
        wrt_im = s_i;
      end
      ST_BF_WR_B: begin
        wrt_en = 1'b1;
        wrt_addr = b_idx;
        wrt_re = dr_q;
        wrt_im = di_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wrt_en) begin
      wk_re_mem[wrt_addr] <= wrt_re;
      wk_im_mem[wrt_addr] <= wrt_im;
    end
  end

  // scale and publish to the result bank
  logic signed [31:0] scaled;
  logic signed [31:0] bias;
  assign bias = wr_q[31] ? 32'(Points - 1) : 32'sd0;
  assign scaled = inv_q ? ($signed(wr_q) + bias) >>> Lg : $signed(wr_q);
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE_WR) begin
      out_re_mem[cnt_lo] <= scaled;
      out_im_mem[cnt_lo] <= inv_q ? 32'd0 : wi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_BF_RD_B: begin
        ur_q <= wr_q;
        ui_q <= wi_q;
      end
      ST_BF_MUL: begin
        p0_q <= $signed(wr_q) * cw_q;
        p1_q <= $signed(wi_q) * wi_tw;
        p2_q <= $signed(wr_q) * wi_tw;
        p3_q <= $signed(wi_q) * cw_q;
      end
      ST_BF_SUM: begin
        tr_q <= t_r;
        ti_q <= t_i;
      end
      ST_BF_WR_A: begin
        dr_q <= d_r;
        di_q <= d_i;
      end
      default: ;
    endcase
  end

  // a is written from the fresh sums, the difference is held for the b write
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    stg_d = stg_q;
    ovf_d = ovf_q;
    case (state_q)
      ST_IDLE: if (job_i.start) begin
        state_d = ST_COPY_RD;
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        if (cnt_q == (Lg+1)'(Points - 1)) begin
          cnt_d = '0;
          stg_d = '0;
          state_d = ST_BF_RD_A;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = ST_COPY_RD;
        end
      end
      ST_BF_RD_A: state_d = ST_BF_RD_B;
      ST_BF_RD_B: state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_SUM;
      ST_BF_SUM: begin
        state_d = ST_BF_WR_A;
        if (ov_mul) ovf_d = 1'b1;
      end
      ST_BF_WR_A: begin
        state_d = ST_BF_WR_B;
        if (ov_bf) ovf_d = 1'b1;
      end
      ST_BF_WR_B: begin
        if (cnt_q == (Lg+1)'(Points / 2 - 1)) begin
          cnt_d = '0;
          if (stg_q == ($bits(stg_q))'(Lg - 1)) state_d = ST_SCALE_RD;
          else begin
            stg_d = stg_q + 1'b1;
            state_d = ST_BF_RD_A;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = ST_BF_RD_A;
        end
      end
      ST_SCALE_RD: state_d = ST_SCALE_WR;
      ST_SCALE_WR: begin
        if (cnt_q == (Lg+1)'(Points - 1)) state_d = ST_IDLE;
        else begin
          cnt_d = cnt_q + 1'b1;
          state_d = ST_SCALE_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      stg_q <= '0;
      ovf_q <= 1'b0;
      done_q <= 1'b0;
      inv_q <= 1'b0;
      center_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      stg_q <= stg_d;
      ovf_q <= ovf_d;
      done_q <= (state_q == ST_SCALE_WR) && (state_d == ST_IDLE);
      if (state_q == ST_IDLE && job_i.start) begin
        inv_q <= job_i.inv;
        center_q <= job_i.center;
      end
    end
  end

  always_comb begin
    stat_o.busy = (state_q != ST_IDLE);
    stat_o.done = done_q;
    stat_o.ovf = ovf_q;
  end

  `FFA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, state_q == ST_IDLE && job_i.start,
    state_q == ST_COPY_RD)
  `FFA_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> state_q == ST_IDLE)
  `FFA_ASSERT(a_stage_range, clk_i, rst_ni, stat_o.busy |-> stg_q < ($bits(stg_q))'(Lg))
endmodule

// File: tb/fixed_point_fft_ifft_test.sv
`timescale 1ns / 100ps

module fixed_point_fft_ifft_test;
  import ffi_pkg::*;

  localparam int unsigned NumItems = 1500;
  localparam int unsigned SettleCycles = 36000;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [9:0] index;
    logic last;
    logic ovf;
  } bin_t;

  class fft_scoreboard;
    bit inverse;
    logic [15:0] center;
    logic signed [31:0] load_re [Points];
    logic signed [31:0] load_im [Points];
    logic signed [31:0] work_re [Points];
    logic signed [31:0] work_im [Points];
    int unsigned load_pos;
    bit have_frame;
    bit frame_ovf;
    bin_t pending_bins[$];
    int errors;
    int checked;

    function new();
      inverse = 0;
      center = 16'd2048;
      load_pos = 0;
      have_frame = 0;
      frame_ovf = 0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h (bin %0d)", what, got, want, checked);
      errors++;
    endtask

    function logic signed [31:0] round_mul(logic signed [31:0] a, logic signed [31:0] w);
      longint p;
      p = longint'(a) * longint'(w) + 64'sd16384;
      return 32'(p >>> 15);
    endfunction

    function logic signed [31:0] add_wrap(logic signed [31:0] a, logic signed [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (((a ^ s) & (b ^ s)) & 32'h80000000) frame_ovf = 1;
      return s;
    endfunction

    function logic signed [31:0] sub_wrap(logic signed [31:0] a, logic signed [31:0] b);
      logic [31:0] s;
      s = a - b;
      if (((a ^ b) & (a ^ s)) & 32'h80000000) frame_ovf = 1;
      return s;
    endfunction

    function void run_fft();
      int unsigned r, tw, a, b, half, stride;
      logic signed [31:0] t, wr, wi, tr, ti, ur, ui, vr, vi;
      frame_ovf = 0;
      for (int i = 0; i < Points; i++) begin
        if (inverse) begin
          work_re[i] = load_re[i];
          work_im[i] = load_im[i];
        end else begin
          work_re[i] = $signed({16'd0, load_re[i][15:0]}) - $signed({16'd0, center});
          work_im[i] = 0;
        end
      end
      for (int i = 0; i < Points; i++) begin
        r = 0;
        for (int k = 0; k < Lg; k++) if (i[k]) r[Lg-1-k] = 1'b1;
        if (r > i) begin
          t = work_re[i]; work_re[i] = work_re[r]; work_re[r] = t;
          t = work_im[i]; work_im[i] = work_im[r]; work_im[r] = t;
        end
      end
      for (int len = 2; len <= Points; len = len * 2) begin
        half = len / 2;
        stride = Points / len;
        for (int k = 0; k < Points; k += len) begin
          for (int j = 0; j < half; j++) begin
            tw = (j * stride) % Points;
            wr = CosTab[tw];
            wi = CosTab[(tw + 3 * Points / 4) % Points];
            if (!inverse) wi = -wi;
            a = k + j;
            b = k + j + half;
            ur = work_re[a]; ui = work_im[a];
            vr = work_re[b]; vi = work_im[b];
            tr = sub_wrap(round_mul(vr, wr), round_mul(vi, wi));
            ti = add_wrap(round_mul(vr, wi), round_mul(vi, wr));
            work_re[a] = add_wrap(ur, tr);
            work_im[a] = add_wrap(ui, ti);
            work_re[b] = sub_wrap(ur, tr);
            work_im[b] = sub_wrap(ui, ti);
          end
        end
      end
      if (inverse) begin
        for (int i = 0; i < Points; i++) begin
          work_re[i] = 32'(longint'(work_re[i]) / longint'(Points));
          work_im[i] = 0;
        end
      end
    endfunction

    function void note_sample(logic signed [31:0] re, logic signed [31:0] im);
      bin_t e;
      if (have_frame) begin
        e.re = work_re[load_pos];
        e.im = work_im[load_pos];
        e.index = load_pos[9:0];
        e.last = (load_pos == Points - 1);
        e.ovf = frame_ovf;
        pending_bins.push_back(e);
      end
      load_re[load_pos] = re;
      load_im[load_pos] = im;
      if (load_pos == Points - 1) begin
        run_fft();
        have_frame = 1;
        load_pos = 0;
      end else begin
        load_pos++;
      end
    endfunction

    task check_bin(bin_t got);
      bin_t e;
      if (pending_bins.size() == 0) begin
        report("unexpected transfer", got.re, 0);
        return;
      end
      e = pending_bins.pop_front();
      if (got.re !== e.re) report("out_re", got.re, e.re);
      if (got.im !== e.im) report("out_im", got.im, e.im);
      if (got.index !== e.index) report("out_index", got.index, e.index);
      if (got.last !== e.last) report("last_of_frame", got.last, e.last);
      if (got.ovf !== e.ovf) report("overflow", got.ovf, e.ovf);
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ffi_stream_if #(.Width(64)) in_if ();
  ffi_stream_if #(.Width(76)) out_if ();

  fixed_point_fft_ifft dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  fft_scoreboard sb = new();
  bit calm;
  bit hold_done;
  longint unsigned cycles;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold;
    bin_t got;
    hold = 0;
    hold_done = 0;
    out_if.ready = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.re = out_if.data[75:44];
        got.im = out_if.data[43:12];
        got.index = out_if.data[11:2];
        got.last = out_if.data[1];
        got.ovf = out_if.data[0];
        sb.check_bin(got);
        if (sb.checked == 200 && !hold_done) begin
          hold = 400;
          hold_done = 1;
        end
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
      end
    end
  end

  task write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == AddrDir) sb.inverse = value[0];
    else if (addr == AddrCenter) sb.center = value[15:0];
  endtask

  task send_sample(logic [31:0] re, logic [31:0] im);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data <= {re, im};
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(re, im);
  endtask

  function logic [31:0] pick_sample(int unsigned frame, int unsigned i, bit real_part);
    logic [31:0] edges [8] = '{32'h0, 32'h0000FFFF, 32'h00008000, 32'h00007FFF,
                               32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF};
    case (frame)
      0, 1, 2, 5: begin
        if (i < 16) return edges[(i + (real_part ? 0 : 3)) % 8] ^ (i >= 8 ? 32'h5A5A0000 : 0);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 65535);
      end
      3: return $urandom_range(0, 1 << 19) - (1 << 18);
      default: begin
        if (i < 20) return edges[(i + (real_part ? 0 : 5)) % 8];
        return $urandom;
      end
    endcase
  endfunction

  initial begin
    bit inv_first;
    bit dir;
    int unsigned frame, pos, kind;
    rst_ni = 0;
    calm = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_if.valid = 0;
    in_if.data = 0;
    inv_first = 1'($urandom_range(0, 1));
    dir = inv_first;
    kind = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    for (int n = 0; n < NumItems; n++) begin
      frame = n / Points;
      pos = n % Points;
      if (pos == 0) begin
        if (frame > 0) begin
          in_if.valid <= 0;
          while (sb.pending_bins.size() != 0) @(posedge clk_i);
          repeat (SettleCycles) @(posedge clk_i);
        end
        dir = (frame == 0) ? inv_first : !inv_first;
        kind = dir ? 4 : 0;
        write_reg(AddrDir, 32'hFFFFFFFE | 32'(dir));
        write_reg(AddrCenter, frame == 0 ? $urandom : 32'd2048);
      end
      calm = (n >= Points + 250 && n < Points + 400);
      send_sample(pick_sample(kind, pos, 1), pick_sample(kind, pos, 0));
    end
    in_if.valid <= 0;
    calm = 0;
    while (sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: fixed_point_fft_ifft.f
+incdir+hdl
hdl/ffi_pkg.sv
hdl/ffi_stream_if.sv
hdl/ffi_engine.sv
hdl/fixed_point_fft_ifft.sv
tb/fixed_point_fft_ifft_test.sv
